/* hw/rtl/lpad_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpad_pkg: shared types and constants of the long-press alarm detector
// Item layouts, mode codes, register indexes and counter widths.
// ----------------------------------------------------------------------------
package lpad_pkg;

   localparam int TIME_BITS  = 16;
   localparam int CFG_BITS   = 16;
   localparam int HOLD_BITS  = 16;
   localparam int BATT_BITS  = 7;
   localparam int CMP_BITS   = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};
   localparam logic [BATT_BITS-1:0] BATT_FULL = BATT_BITS'(100);

   localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(3000);
   localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET   = CFG_BITS'(50);
   localparam logic [CFG_BITS-1:0] VIBRATE_RESET    = CFG_BITS'(200);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_DEBOUNCE   = 2'd1,
      CSR_VIBRATE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_PRESSING  = 2'd1,
      MODE_TRIGGERED = 2'd2,
      MODE_COOLDOWN  = 2'd3
   } mode_type;

   typedef struct packed {
      logic                 tick;
      logic                 edge_valid;
      logic                 button_level;
      logic                 force_trigger;
      logic                 clear_latch;
      logic                 reset_request;
      logic [BATT_BITS-1:0] charge_pct;
   } req_item_type;

   typedef struct packed {
      mode_type             mode;
      logic                 alarm_event;
      logic [HOLD_BITS-1:0] hold_ms;
      logic [BATT_BITS-1:0] event_battery;
      logic                 latch_value;
      logic                 motor_on;
   } rsp_item_type;

   // handshake between the input register and the rest of the pipe
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

endpackage
`default_nettype wire

/* hw/rtl/long_press_alarm_detector.sv */
// A request passes the input register, then the result register, before its result is valid.
// One item per cycle while rsp_stall is low; the step logic between the registers sets this.
// A stalled result holds in the result register while the input register takes one more item.
// Reset is synchronous, active high: mode idle, counters, latch and captures cleared,
// registers back to 3000, 50 and 200 ms; no clearing pass is needed.
`default_nettype none
// ----------------------------------------------------------------------------
// long_press_alarm_detector: top level
// Input register, detector step and result register in one pass.
// ----------------------------------------------------------------------------
module long_press_alarm_detector import lpad_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire req_item_type            req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output rsp_item_type                 rsp_data,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_wdata
);

   stage_ctrl_type ctrl;
   req_item_type   item;
   rsp_item_type   result;
   logic           advance;

   lpad_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .ctrl      (ctrl),
      .item      (item)
   );

   lpad_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctrl      (ctrl),
      .item      (item),
      .result    (result)
   );

   lpad_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* hw/rtl/lpad_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpad_in_stage: input item register
// Captures one request item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lpad_in_stage import lpad_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire req_item_type   req_data,
   input  wire logic           advance,
   output stage_ctrl_type      ctrl,
   output req_item_type        item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   assign ctrl.valid   = valid_ff;
   assign ctrl.advance = advance;
   assign item         = item_ff;

endmodule
`default_nettype wire

/* hw/rtl/lpad_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpad_core: detector state and per-item step
// Holds configuration, mode, counters and alarm capture; works out one
// result item from the registered request item.
// ----------------------------------------------------------------------------
module lpad_core import lpad_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_wdata,
   input  wire stage_ctrl_type          ctrl,
   input  wire req_item_type            item,
   output rsp_item_type                 result
);

   logic [CFG_BITS-1:0]  long_press_ff, debounce_ff, vibrate_ff;
   mode_type             mode_ff, mode_in;
   logic [TIME_BITS-1:0] press_ff, press_in;
   logic [TIME_BITS-1:0] cool_ff, cool_in;
   logic                 latch_ff, latch_in;
   logic [CFG_BITS-1:0]  motor_ff, motor_in;
   logic [HOLD_BITS-1:0] hold_ff, hold_in;
   logic [BATT_BITS-1:0] batt_ff, batt_in;
   logic                 fire;
   logic                 latch_seen;
   logic                 step;

   assign step = ctrl.valid && ctrl.advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= LONG_PRESS_RESET;
         debounce_ff   <= DEBOUNCE_RESET;
         vibrate_ff    <= VIBRATE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata;
            CSR_VIBRATE:    vibrate_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      press_in = press_ff;
      cool_in  = cool_ff;
      latch_in = latch_ff;
      motor_in = motor_ff;
      hold_in  = hold_ff;
      batt_in  = batt_ff;
      fire     = 1'b0;

      if (item.reset_request) begin
         mode_in  = MODE_IDLE;
         latch_in = 1'b0;
      end

      if (item.tick) begin
         if (press_in != TIME_MAX) begin
            press_in = press_in + 1'b1;
         end
         if (motor_in != '0) begin
            motor_in = motor_in - 1'b1;
         end
         if (mode_in == MODE_PRESSING) begin
            if (CMP_BITS'(press_in) >= CMP_BITS'(long_press_ff)) begin
               mode_in = MODE_TRIGGERED;
               fire    = 1'b1;
            end
         end else if (mode_in == MODE_COOLDOWN) begin
            if (cool_in != TIME_MAX) begin
               cool_in = cool_in + 1'b1;
            end
            if (CMP_BITS'(cool_in) >= CMP_BITS'(debounce_ff)) begin
               mode_in = MODE_IDLE;
            end
         end
      end

      if (item.edge_valid) begin
         if (!item.button_level) begin
            if (mode_in == MODE_IDLE) begin
               mode_in  = MODE_PRESSING;
               press_in = '0;
            end
         end else if (mode_in == MODE_PRESSING || mode_in == MODE_TRIGGERED) begin
            mode_in = MODE_COOLDOWN;
            cool_in = '0;
         end
      end

      // automatic and forced alarm in one item count as one
      if (item.force_trigger) begin
         fire = 1'b1;
      end

      if (fire) begin
         latch_in = 1'b1;
         if (CMP_BITS'(press_in) > CMP_BITS'(HOLD_MAX)) begin
            hold_in = HOLD_MAX;
         end else begin
            hold_in = HOLD_BITS'(press_in);
         end
         batt_in  = (item.charge_pct > BATT_FULL) ? BATT_FULL : item.charge_pct;
         motor_in = vibrate_ff;
      end

      latch_seen = latch_in;
      if (item.clear_latch) begin
         latch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         press_ff <= '0;
         cool_ff  <= '0;
         latch_ff <= 1'b0;
         motor_ff <= '0;
         hold_ff  <= '0;
         batt_ff  <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         press_ff <= press_in;
         cool_ff  <= cool_in;
         latch_ff <= latch_in;
         motor_ff <= motor_in;
         hold_ff  <= hold_in;
         batt_ff  <= batt_in;
      end
   end

   assign result.mode          = mode_in;
   assign result.alarm_event   = fire;
   assign result.hold_ms       = hold_in;
   assign result.event_battery = batt_in;
   assign result.latch_value   = latch_seen;
   assign result.motor_on      = (motor_in != '0);

endmodule
`default_nettype wire

/* hw/rtl/lpad_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpad_out_stage: result item register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module lpad_out_stage import lpad_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stage_ctrl_type ctrl,
   input  wire rsp_item_type   result,
   output logic                advance,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output rsp_item_type        rsp_data
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;
   logic         free;
   logic         load;

   assign free    = !valid_ff || !rsp_stall;
   assign advance = free;
   assign load    = ctrl.valid && ctrl.advance;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

/* hw/rtl/lpad_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpad_checker: port-level checks of the detector
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module lpad_checker import lpad_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire req_item_type            req_data,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire rsp_item_type            rsp_data
);

   // hold a stalled request
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request item changed");

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_alarm_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.alarm_event |-> rsp_data.latch_value)
      else $error("alarm item without latch set");

   a_batt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_battery <= BATT_FULL)
      else $error("captured battery above full charge");

endmodule

bind long_press_alarm_detector lpad_checker u_lpad_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
